// File: rtl/tcoc_pkg.sv
// Package for the transitive closure order checker.
// Holds field widths, verdict and mode codes, the register index, matrix opcodes and structs.
// No dependencies.
package tcoc_pkg;

  // Width of a letter index and of a predecessor count.
  localparam int LW = 5;
  // Width of the decided_after result field.
  localparam int DEC_W = 10;

  localparam logic [LW-1:0] LETTER_COUNT_RESET = 5'd26;
  localparam logic [LW-1:0] LETTER_COUNT_MIN   = 5'd2;

  // Index of the letter_count register on the configuration port.
  localparam logic REG_LETTER_COUNT = 1'b0;

  localparam logic [1:0] V_UNDET  = 2'd0;
  localparam logic [1:0] V_DET    = 2'd1;
  localparam logic [1:0] V_INCONS = 2'd2;

  localparam logic MODE_CLEAR    = 1'b0;
  localparam logic MODE_RELATION = 1'b1;

  localparam logic [1:0] OP_IDLE  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;
  localparam logic [1:0] OP_CLOSE = 2'd3;

  // Command from the sequencer to the matrix unit.
  typedef struct packed {
    logic [1:0]    op;
    logic [LW-1:0] idx;   // pivot row, judged row or counted column
    logic [LW-1:0] aux;   // column of a new relation
    logic [LW-1:0] n;     // number of active letters
  } mat_cmd_t;

  // Status of the matrix unit for the row or column under cmd.idx.
  typedef struct packed {
    logic          conflict;
    logic          open;
    logic [LW-1:0] cnt;
  } mat_stat_t;

endpackage

// File: rtl/tcoc_matrix.sv
// Reachability matrix whose rows all update in parallel for each closure pivot.
// Also reports per-row pair checks and per-column predecessor counts.
// Depends on tcoc_pkg.
module tcoc_matrix
  import tcoc_pkg::*;
#(
  parameter int MAX_LETTERS = 26
) (
  input  logic      clk,
  input  logic      rst,
  input  mat_cmd_t  cmd,
  output mat_stat_t stat
);

  localparam int IDX_W = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;

  logic [MAX_LETTERS-1:0] rows [MAX_LETTERS];
  logic [MAX_LETTERS-1:0] act_mask;
  logic [MAX_LETTERS-1:0] gt_mask;
  logic [MAX_LETTERS-1:0] diag;
  logic [MAX_LETTERS-1:0] pivot;
  logic [MAX_LETTERS-1:0] col;
  logic [IDX_W-1:0]       sel;

  assign sel   = cmd.idx[IDX_W-1:0];
  assign pivot = rows[sel];

  always_comb begin
    for (int j = 0; j < MAX_LETTERS; j++) begin
      act_mask[j] = LW'(j) < cmd.n;
      gt_mask[j]  = act_mask[j] && (LW'(j) > cmd.idx);
      diag[j]     = LW'(j) == cmd.idx;
      col[j]      = rows[j][sel];
    end
  end

  // Pivot row holds bits i<j, the column holds j<i: a pair must be related exactly once.
  assign stat.conflict = |(pivot & col & gt_mask);
  assign stat.open     = |(~pivot & ~col & gt_mask);
  assign stat.cnt      = LW'($countones(col & act_mask & ~diag));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LETTERS; i++) begin
        rows[i] <= '0;
      end
    end else begin
      unique case (cmd.op)
        OP_CLEAR: begin
          for (int i = 0; i < MAX_LETTERS; i++) begin
            rows[i] <= '0;
          end
        end
        OP_SET: begin
          rows[sel][cmd.aux[IDX_W-1:0]] <= 1'b1;
        end
        OP_CLOSE: begin
          // The pivot row itself cannot change in its own step, so all rows update at once.
          for (int i = 0; i < MAX_LETTERS; i++) begin
            if (act_mask[i] && col[i]) begin
              rows[i] <= rows[i] | (pivot & act_mask);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/transitive_closure_order_check_top.sv
// A clear item or an ignored relation goes from dispatch straight to its single reply.
// An accepted relation runs the closure and the pair check (n active letters: one closure step
// per row, one check per row); a new item is taken only when the sequencer is idle.
// A relation that settles the order puts n counting steps and n emitted letters in place
// of the reply, and the next item is taken after the last letter.
// Reset is synchronous and active high: matrix, verdict and counts clear, letter_count is 26.
module transitive_closure_order_check_top
  import tcoc_pkg::*;
#(
  parameter int MAX_LETTERS   = 26,
  parameter int MAX_RELATIONS = 1023
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [4:0] lesser_letter, [9:5] greater_letter
  input  logic        s_tuser,   // mode: 0 clears the case, 1 adds a relation
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [1:0] verdict, [11:2] decided_after, [16:12] order_letter
  output logic        m_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
  localparam int CNT_W = $clog2(MAX_RELATIONS + 1);
  localparam logic [LW-1:0]    N_MAX   = LW'(MAX_LETTERS);
  localparam logic [CNT_W-1:0] REL_MAX = CNT_W'(MAX_RELATIONS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_CLOSE    = 3'd2;
  localparam logic [2:0] S_JUDGE    = 3'd3;
  localparam logic [2:0] S_COUNT    = 3'd4;
  localparam logic [2:0] S_EMIT     = 3'd5;
  localparam logic [2:0] S_REPLY    = 3'd6;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [LW-1:0]    step;
  logic [LW-1:0]    step_next;
  logic [1:0]       verdict_reg;
  logic [1:0]       verdict_reg_next;
  logic [CNT_W-1:0] relation_count;
  logic [CNT_W-1:0] relation_count_next;
  logic [CNT_W-1:0] decided_at;
  logic [CNT_W-1:0] decided_at_next;
  logic             acc_conflict;
  logic             acc_conflict_next;
  logic             acc_open;
  logic             acc_open_next;
  logic [LW-1:0]    letter_count;

  // Item held while it is worked on.
  logic             mode_q;
  logic [LW-1:0]    lesser_q;
  logic [LW-1:0]    greater_q;

  // Letters by rank, written while counting predecessors.
  logic [LW-1:0]    ord [MAX_LETTERS];

  // Output register.
  logic [1:0]       out_verdict;
  logic [DEC_W-1:0] out_dec;
  logic [LW-1:0]    out_letter;

  logic             load;
  logic             load_last;
  logic             out_free;
  logic [LW-1:0]    n_act;
  logic [LW-1:0]    n_last;
  logic             step_done;
  logic             rel_ok;
  logic             conf_all;
  logic             open_all;
  logic [31:0]      dec_ext;
  logic             cfg_write;

  mat_cmd_t  cmd;
  mat_stat_t stat;

  tcoc_matrix #(
    .MAX_LETTERS(MAX_LETTERS)
  ) u_matrix (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .stat(stat)
  );

  // The register takes effect at once; values outside 2..MAX_LETTERS are clamped here.
  always_comb begin
    priority if (letter_count < LETTER_COUNT_MIN) begin
      n_act = LETTER_COUNT_MIN;
    end else if (letter_count > N_MAX) begin
      n_act = N_MAX;
    end else begin
      n_act = letter_count;
    end
  end

  assign n_last    = n_act - LW'(1);
  assign step_done = step == n_last;
  assign rel_ok    = (verdict_reg == V_UNDET) && (lesser_q < n_act) && (greater_q < n_act);
  assign conf_all  = acc_conflict | stat.conflict;
  assign open_all  = acc_open | stat.open;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = state == S_IDLE;

  // Configuration port: writes land in the access phase, reads return the register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_LETTER_COUNT) ? {{(32 - LW){1'b0}}, letter_count} : '0;

  // The matrix command follows the sequencer state; counters address rows and columns.
  always_comb begin
    cmd.op  = OP_IDLE;
    cmd.idx = step;
    cmd.aux = greater_q;
    cmd.n   = n_act;
    unique case (state)
      S_DISPATCH: begin
        if (mode_q == MODE_CLEAR) begin
          cmd.op = OP_CLEAR;
        end else if (rel_ok) begin
          cmd.op  = OP_SET;
          cmd.idx = lesser_q;
        end
      end
      S_CLOSE: cmd.op = OP_CLOSE;
      default: begin
      end
    endcase
  end

  // Sequencer: dispatch, then for an accepted relation closure over n pivots and pair check over
  // n rows; then either one reply transfer or, when the order first settles, n counting steps and n letters.
  always_comb begin
    state_next          = state;
    step_next           = step;
    verdict_reg_next    = verdict_reg;
    relation_count_next = relation_count;
    decided_at_next     = decided_at;
    acc_conflict_next   = acc_conflict;
    acc_open_next       = acc_open;
    load                = 1'b0;
    load_last           = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        step_next = '0;
        if (mode_q == MODE_CLEAR) begin
          verdict_reg_next    = V_UNDET;
          relation_count_next = '0;
          decided_at_next     = '0;
          state_next          = S_REPLY;
        end else if (rel_ok) begin
          if (relation_count < REL_MAX) begin
            relation_count_next = relation_count + CNT_W'(1);
          end
          state_next = S_CLOSE;
        end else begin
          // Sticky verdict or a letter outside the active set: answer with what is held.
          state_next = S_REPLY;
        end
      end
      S_CLOSE: begin
        if (step_done) begin
          step_next         = '0;
          acc_conflict_next = 1'b0;
          acc_open_next     = 1'b0;
          state_next        = S_JUDGE;
        end else begin
          step_next = step + LW'(1);
        end
      end
      S_JUDGE: begin
        acc_conflict_next = conf_all;
        acc_open_next     = open_all;
        if (step_done) begin
          step_next = '0;
          priority if (conf_all) begin
            verdict_reg_next = V_INCONS;
            decided_at_next  = relation_count;
            state_next       = S_REPLY;
          end else if (open_all) begin
            state_next = S_REPLY;
          end else begin
            verdict_reg_next = V_DET;
            decided_at_next  = relation_count;
            state_next       = S_COUNT;
          end
        end else begin
          step_next = step + LW'(1);
        end
      end
      S_COUNT: begin
        if (step_done) begin
          step_next  = '0;
          state_next = S_EMIT;
        end else begin
          step_next = step + LW'(1);
        end
      end
      S_EMIT: begin
        load_last = step_done;
        if (out_free) begin
          load = 1'b1;
          if (step_done) begin
            state_next = S_IDLE;
          end else begin
            step_next = step + LW'(1);
          end
        end
      end
      S_REPLY: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      step           <= '0;
      verdict_reg    <= V_UNDET;
      relation_count <= '0;
      decided_at     <= '0;
      acc_conflict   <= 1'b0;
      acc_open       <= 1'b0;
      letter_count   <= LETTER_COUNT_RESET;
      m_tvalid       <= 1'b0;
    end else begin
      state          <= state_next;
      step           <= step_next;
      verdict_reg    <= verdict_reg_next;
      relation_count <= relation_count_next;
      decided_at     <= decided_at_next;
      acc_conflict   <= acc_conflict_next;
      acc_open       <= acc_open_next;
      if (cfg_write && (paddr[2] == REG_LETTER_COUNT)) begin
        letter_count <= pwdata[LW-1:0];
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign dec_ext = 32'(decided_at);

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      mode_q    <= s_tuser;
      lesser_q  <= s_tdata[4:0];
      greater_q <= s_tdata[9:5];
    end
    // In a settled order the predecessor counts are exactly 0..n-1, one per letter.
    if (state == S_COUNT) begin
      ord[stat.cnt[IDX_W-1:0]] <= step;
    end
    if (load) begin
      out_verdict <= verdict_reg;
      out_dec     <= dec_ext[DEC_W-1:0];
      out_letter  <= (state == S_EMIT) ? ord[step[IDX_W-1:0]] : '0;
      m_tlast     <= load_last;
    end
  end

  assign m_tdata = {7'b0, out_letter, out_dec, out_verdict};

  // Letters are only ever emitted for a settled order.
  a_emit_determined: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (verdict_reg == V_DET))
    else $error("letters emitted without a determined verdict");

  // A decision number exists only alongside a sticky verdict.
  a_decided_sticky: assert property (@(posedge clk) disable iff (rst)
    (decided_at != '0) |-> (verdict_reg != V_UNDET))
    else $error("decision number held while undetermined");

  // A relation after a sticky verdict changes neither verdict nor count.
  a_sticky_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISPATCH && mode_q == MODE_RELATION && verdict_reg != V_UNDET) |=>
      (verdict_reg == $past(verdict_reg) && relation_count == $past(relation_count)))
    else $error("sticky verdict disturbed by a later relation");

endmodule

// File: sim/tb.sv
// Self-checking testbench for transitive_closure_order_check_top.
// Depends on tcoc_pkg (field widths, verdict and mode codes) and the top level RTL only.
// A directed table is followed by random relation sequences; typed rows carry hand-written results.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcoc_pkg::*;

  localparam int LETTERS        = 26;
  localparam int REL_LIMIT      = 1023;
  localparam int RANDOM_ITEMS   = 300;
  localparam int QUIET_LIMIT    = 5000;
  // Worst case for one transfer: n closure steps, n checks, n counts, n letters.
  localparam int DRAIN_CYCLES   = 4 * LETTERS + 11;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // One row of the directed table. For ROW_CFG the lesser field holds the register value.
  typedef struct {
    row_kind_e  kind;
    logic       mode;
    int         lesser;
    int         greater;
    bit         typed;
    logic [1:0] verdict;
    logic [9:0] decided;
  } stim_row_t;

  typedef struct packed {
    logic [1:0]       verdict;
    logic [DEC_W-1:0] decided_after;
    logic [LW-1:0]    order_letter;
    logic             last;
  } order_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [4:0] lesser_letter, [9:5] greater_letter
  logic        s_tuser;   // mode
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // [1:0] verdict, [11:2] decided_after, [16:12] order_letter
  logic        m_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  transitive_closure_order_check_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor state: our own copy of the reachability matrix and the sticky verdict.
  logic [LETTERS-1:0] reach [LETTERS];
  logic [1:0]         held_verdict;
  logic [DEC_W-1:0]   relation_no;
  logic [DEC_W-1:0]   decided_no;
  logic [LW-1:0]      letter_cnt;

  order_result_t pending_results[$];
  stim_row_t     directed_rows[$];

  int mismatches;
  int items_sent;
  int results_seen;
  int emissions;
  int quiet_cycles;
  int idle_pct;
  int stall_pct;
  int widest;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int active_count(input logic [LW-1:0] value);
    if (value < 2) return 2;
    if (value > LETTERS) return LETTERS;
    return int'(value);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("MISMATCH at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic push_result(input logic [1:0] v, input logic [DEC_W-1:0] d,
                             input int letter, input logic lst);
    order_result_t r;
    r.verdict       = v;
    r.decided_after = d;
    r.order_letter  = letter[LW-1:0];
    r.last          = lst;
    pending_results.insert(pending_results.size(), r);
  endtask

  // Applies one accepted transfer to the predictor: closure, verdict and, when the order is
  // first settled, the letters ranked by how many letters precede each one.
  task automatic close_and_judge(input logic mode, input int lesser, input int greater);
    int n, i, j, k, r, best;
    int preds[LETTERS];
    bit taken[LETTERS];
    bit loose_pair, clash;
    logic [LETTERS-1:0] mask;
    n = active_count(letter_cnt);
    mask = (26'd1 << n) - 26'd1;
    if (n > widest) widest = n;
    if (mode == MODE_CLEAR) begin
      for (i = 0; i < LETTERS; i++) reach[i] = '0;
      held_verdict = V_UNDET;
      relation_no  = '0;
      decided_no   = '0;
      push_result(V_UNDET, '0, 0, 1'b1);
      return;
    end
    // Sticky verdicts and letters outside the active set leave everything untouched.
    if (held_verdict != V_UNDET || lesser >= n || greater >= n) begin
      push_result(held_verdict, decided_no, 0, 1'b1);
      return;
    end
    if (relation_no < REL_LIMIT) relation_no++;
    reach[lesser][greater] = 1'b1;
    for (k = 0; k < n; k++)
      for (i = 0; i < n; i++)
        if (reach[i][k]) reach[i] = reach[i] | (reach[k] & mask);
    loose_pair = 1'b0;
    clash      = 1'b0;
    for (i = 0; i < n; i++)
      for (j = i + 1; j < n; j++)
        if (reach[i][j] == reach[j][i]) begin
          if (reach[i][j]) clash = 1'b1;
          else loose_pair = 1'b1;
        end
    held_verdict = clash ? V_INCONS : (loose_pair ? V_UNDET : V_DET);
    if (held_verdict == V_UNDET) begin
      push_result(V_UNDET, '0, 0, 1'b1);
      return;
    end
    decided_no = relation_no;
    if (held_verdict == V_INCONS) begin
      push_result(V_INCONS, decided_no, 0, 1'b1);
      return;
    end
    emissions++;
    for (j = 0; j < n; j++) begin
      preds[j] = 0;
      taken[j] = 1'b0;
      for (i = 0; i < n; i++)
        if (i != j && reach[i][j]) preds[j]++;
    end
    // Lowest predecessor count first; ties go to the lower letter.
    for (r = 0; r < n; r++) begin
      best = -1;
      for (j = 0; j < n; j++)
        if (!taken[j] && (best < 0 || preds[j] < preds[best])) best = j;
      taken[best] = 1'b1;
      push_result(V_DET, decided_no, best, r == n - 1);
    end
  endtask

  // Presents one item and waits for its transfer. Always entered and left at a falling edge.
  // A typed row replaces what the predictor produced with the hand-written single result,
  // while the predictor state still advances.
  task automatic send_item(input logic mode, input int lesser, input int greater,
                           input bit typed = 1'b0, input logic [1:0] tv = V_UNDET,
                           input logic [DEC_W-1:0] td = '0);
    int queued;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {6'd0, greater[LW-1:0], lesser[LW-1:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    queued = pending_results.size();
    close_and_judge(mode, lesser, greater);
    if (typed) begin
      while (pending_results.size() > queued)
        pending_results.delete(pending_results.size() - 1);
      push_result(tv, td, 0, 1'b1);
    end
    @(negedge clk);
  endtask

  // Holds the sender off until every expected result has been collected.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Setup and access phases; the register takes the value at the access edge.
  task automatic write_letter_count(input int value);
    wait_drained();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {REG_LETTER_COUNT, 2'b00};
    pwdata  <= {27'd0, value[LW-1:0]};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    letter_cnt = value[LW-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic add_row(input row_kind_e kind, input logic mode, input int lesser,
                         input int greater, input bit typed = 1'b0,
                         input logic [1:0] v = V_UNDET, input int d = 0);
    stim_row_t row;
    row.kind    = kind;
    row.mode    = mode;
    row.lesser  = lesser;
    row.greater = greater;
    row.typed   = typed;
    row.verdict = v;
    row.decided = d[DEC_W-1:0];
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // One case: a clear, then either a shuffled chain of consistent relations (mostly), with
  // some noise and a rare reversed pair, or a run of arbitrary relations and letter count writes.
  task automatic random_case(input int n_in);
    int ranks[LETTERS];
    int pair_lo[$];
    int pair_hi[$];
    int i, j, t, n, extra;
    n = n_in;
    for (i = 0; i < n; i++) ranks[i] = i;
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = ranks[i];
      ranks[i] = ranks[j];
      ranks[j] = t;
    end
    // Letter fields of a clear carry no meaning, so they are random here.
    send_item(MODE_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31));
    if ($urandom_range(0, 99) < 75) begin
      for (i = 0; i < n - 1; i++) begin
        pair_lo.insert(pair_lo.size(), ranks[i]);
        pair_hi.insert(pair_hi.size(), ranks[i + 1]);
      end
      extra = $urandom_range(0, n / 2);
      repeat (extra) begin
        i = $urandom_range(0, n - 2);
        j = $urandom_range(i + 1, n - 1);
        pair_lo.insert(pair_lo.size(), ranks[i]);
        pair_hi.insert(pair_hi.size(), ranks[j]);
      end
      for (i = pair_lo.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = pair_lo[i]; pair_lo[i] = pair_lo[j]; pair_lo[j] = t;
        t = pair_hi[i]; pair_hi[i] = pair_hi[j]; pair_hi[j] = t;
      end
      for (i = 0; i < pair_lo.size(); i++) begin
        t = $urandom_range(0, 99);
        if (t < 4) wait_drained();
        if (t < 8) begin
          if ($urandom_range(0, 1)) send_item(MODE_RELATION, $urandom_range(n, 31),
                                              $urandom_range(0, 31));
          else send_item(MODE_RELATION, $urandom_range(0, 31), $urandom_range(n, 31));
        end else if (t < 11) begin
          send_item(MODE_RELATION, pair_hi[i], pair_lo[i]);
        end
        send_item(MODE_RELATION, pair_lo[i], pair_hi[i]);
      end
      // Anything after the verdict has settled must be ignored.
      repeat ($urandom_range(0, 2))
        send_item(MODE_RELATION, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
    end else begin
      repeat ($urandom_range(2, 2 * n)) begin
        t = $urandom_range(0, 99);
        if (t < 10) begin
          send_item(MODE_RELATION, $urandom_range(0, 31), $urandom_range(0, 31));
        end else if (t < 15) begin
          i = $urandom_range(0, n - 1);
          send_item(MODE_RELATION, i, i);
        end else if (t < 19) begin
          // The matrix survives a change of the letter count.
          write_letter_count($urandom_range(0, 31));
          n = active_count(letter_cnt);
        end else begin
          send_item(MODE_RELATION, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
        end
      end
    end
  endtask

  // Result checker: every result transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    order_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, verdict", m_tdata[1:0], -1);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[1:0] !== want.verdict)
          report_mismatch("verdict", m_tdata[1:0], want.verdict);
        if (m_tdata[11:2] !== want.decided_after)
          report_mismatch("decided_after", m_tdata[11:2], want.decided_after);
        if (m_tdata[16:12] !== want.order_letter)
          report_mismatch("order_letter", m_tdata[16:12], want.order_letter);
        if (m_tlast !== want.last)
          report_mismatch("last", m_tlast, want.last);
      end
    end
  end

  // Receiver stalls are drawn every cycle.
  always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= stall_pct);

  // Counts cycles in which nothing moves on either stream or the register port.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: nothing transferred for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, pending_results.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    int ph, phase_start, first_value;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = MODE_CLEAR;
    m_tready     = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    mismatches   = 0;
    items_sent   = 0;
    results_seen = 0;
    emissions    = 0;
    quiet_cycles = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    widest       = 0;
    for (int i = 0; i < LETTERS; i++) reach[i] = '0;
    held_verdict = V_UNDET;
    relation_no  = '0;
    decided_no   = '0;
    letter_cnt   = LETTER_COUNT_RESET;

    // Directed table. After reset all 26 letters are active.
    add_row(ROW_ITEM, MODE_RELATION, 0, 25, 1, V_UNDET, 0);
    add_row(ROW_ITEM, MODE_RELATION, 25, 0, 1, V_INCONS, 2);    // A<Z then Z<A
    add_row(ROW_ITEM, MODE_RELATION, 3, 4, 1, V_INCONS, 2);     // ignored, verdict held
    add_row(ROW_ITEM, MODE_RELATION, 31, 31, 1, V_INCONS, 2);
    add_row(ROW_ITEM, MODE_CLEAR, 31, 31, 1, V_UNDET, 0);
    add_row(ROW_ITEM, MODE_RELATION, 25, 25, 1, V_UNDET, 0);    // self relation goes unnoticed
    add_row(ROW_ITEM, MODE_RELATION, 31, 0, 1, V_UNDET, 0);     // letters beyond the set
    add_row(ROW_ITEM, MODE_RELATION, 0, 26, 1, V_UNDET, 0);
    add_row(ROW_ITEM, MODE_CLEAR, 0, 0, 1, V_UNDET, 0);
    add_row(ROW_CFG, MODE_CLEAR, 2, 0);
    add_row(ROW_ITEM, MODE_RELATION, 0, 1);                     // settles A B
    add_row(ROW_ITEM, MODE_RELATION, 1, 0, 1, V_DET, 1);
    add_row(ROW_ITEM, MODE_CLEAR, 0, 0, 1, V_UNDET, 0);
    add_row(ROW_ITEM, MODE_RELATION, 2, 0, 1, V_UNDET, 0);
    add_row(ROW_ITEM, MODE_RELATION, 1, 0);                     // settles B A
    add_row(ROW_ITEM, MODE_CLEAR, 0, 0, 1, V_UNDET, 0);
    add_row(ROW_ITEM, MODE_RELATION, 0, 0, 1, V_UNDET, 0);
    add_row(ROW_CFG, MODE_CLEAR, 0, 0);                         // below the range acts as 2
    add_row(ROW_ITEM, MODE_RELATION, 1, 0);
    add_row(ROW_ITEM, MODE_CLEAR, 0, 0, 1, V_UNDET, 0);
    add_row(ROW_CFG, MODE_CLEAR, 31, 0);                        // above the range acts as 26
    add_row(ROW_ITEM, MODE_RELATION, 25, 24);
    add_row(ROW_CFG, MODE_CLEAR, 3, 0);
    add_row(ROW_ITEM, MODE_RELATION, 0, 1);
    add_row(ROW_ITEM, MODE_RELATION, 1, 2);                     // closure settles A B C
    add_row(ROW_ITEM, MODE_RELATION, 2, 0, 1, V_DET, 3);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_letter_count(directed_rows[i].lesser);
      else
        send_item(directed_rows[i].mode, directed_rows[i].lesser, directed_rows[i].greater,
                  directed_rows[i].typed, directed_rows[i].verdict,
                  directed_rows[i].decided);
    end

    // Four idling phases: none, sender idle, receiver stalling, both.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  first_value = 26; end
        1: begin idle_pct = 83; stall_pct = 0;  first_value = 31; end
        2: begin idle_pct = 0;  stall_pct = 83; first_value = 1;  end
        default: begin idle_pct = 28; stall_pct = 28; first_value = 26; end
      endcase
      write_letter_count(first_value);
      phase_start = items_sent;
      while (items_sent - phase_start < RANDOM_ITEMS / 4) begin
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 3))
            0: write_letter_count($urandom_range(0, 1));
            1: write_letter_count($urandom_range(26, 31));
            default: write_letter_count($urandom_range(2, 9));
          endcase
        end
        random_case(active_count(letter_cnt));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_results.size());

    $display("covered %0d input transfers and %0d result transfers, %0d settled orders",
             items_sent, results_seen, emissions);
    $display("letter counts up to %0d active letters, four idling mixes, %0d mismatches",
             widest, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tcoc_pkg.sv
rtl/tcoc_matrix.sv
rtl/transitive_closure_order_check_top.sv
sim/tb.sv
